### hw/rtl/ccf_pkg.sv
// ----------------------------------------------------------------------------
// ccf_pkg: shared constants and helpers for the clamped Cholesky factor
// Fixed-point widths, store geometry and the active-dimension clamp.
// ----------------------------------------------------------------------------
package ccf_pkg;

	localparam int MAX_DIM    = 8;
	localparam int IDX_W      = 3;               // row / column index
	localparam int DIM_W      = 4;               // matrix_size register
	localparam int ADDR_W     = 2 * IDX_W;       // store address
	localparam int CNT_W      = 7;               // load counter
	localparam int DATA_W     = 32;              // Q16.16 word
	localparam int FRAC_W     = 16;
	localparam int PROD_W     = 2 * DATA_W;      // exact product
	localparam int ACC_W      = 52;              // running sum, 7 terms max
	localparam int RAD_W      = DATA_W + FRAC_W; // sqrt radicand / dividend
	localparam int ROOT_W     = RAD_W / 2;
	localparam int ITER_W     = 6;

	localparam logic [DIM_W-1:0]  RESET_DIM = DIM_W'(MAX_DIM);
	localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// zero acts as one, anything above MAX_DIM acts as MAX_DIM
	function automatic logic [DIM_W-1:0] active_dim(input logic [DIM_W-1:0] sz);
		logic [DIM_W-1:0] n;
		n = sz;
		if (sz == '0)
			n = DIM_W'(1);
		else if (sz > DIM_W'(MAX_DIM))
			n = DIM_W'(MAX_DIM);
		return n;
	endfunction

endpackage

### hw/rtl/clamped_cholesky_factor.sv
// Input: n*n transfers, one per cycle while in_stall is low; the last one starts the factorization.
// Each lower-triangle entry (i,j) runs a multiply-accumulate over j products, then a
// square root (diagonal) or a division (off-diagonal).
// Output: n*n result transfers, one at a time through S_ERD, S_EOUT and S_EHOLD; inputs stall meanwhile.
// The run time is set by the one shared multiplier and the bit-serial root/divide unit.
// Reset (arst_n low): size 8, load count 0, block idle and ready; stores are not cleared.
// ----------------------------------------------------------------------------
// clamped_cholesky_factor
// Loads a square Q16.16 matrix, computes its lower Cholesky factor with
// clamped pivots and saturated quotients, and streams the factor row-major.
// ----------------------------------------------------------------------------
module clamped_cholesky_factor (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 matrix_size_we,
	input  logic [ccf_pkg::DIM_W-1:0]            matrix_size,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [ccf_pkg::DATA_W-1:0]    matrix_element,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [ccf_pkg::DATA_W-1:0]    factor_element,
	output logic [ccf_pkg::IDX_W-1:0]            row_index,
	output logic [ccf_pkg::IDX_W-1:0]            column_index,
	output logic                                 last_of_run
);

	typedef enum logic [3:0] {
		S_LOAD, S_MREAD, S_MWAIT, S_FRD, S_MUL, S_ACC, S_FIN,
		S_PIV, S_SQRT, S_DIV, S_WR, S_ERD, S_EOUT, S_EHOLD
	} state_t;

	state_t state_q;

	logic [ccf_pkg::DIM_W-1:0]  size_q;
	logic [ccf_pkg::CNT_W-1:0]  load_q;
	logic [ccf_pkg::IDX_W-1:0]  i_q, j_q, k_q;
	logic [ccf_pkg::ITER_W-1:0] iter_q;

	logic signed [ccf_pkg::ACC_W-1:0]   acc_q;
	logic signed [ccf_pkg::DATA_W-1:0]  s_q;
	logic signed [ccf_pkg::PROD_W-1:0]  prod_q;
	logic signed [ccf_pkg::DATA_W-1:0]  entry_q;
	logic        [ccf_pkg::RAD_W-1:0]   rad_q;     // radicand or dividend shifter
	logic        [ccf_pkg::ROOT_W+2:0]  srem_q;
	logic        [ccf_pkg::ROOT_W-1:0]  root_q;
	logic        [ccf_pkg::DATA_W:0]    drem_q;
	logic        [ccf_pkg::RAD_W-1:0]   quot_q;
	logic        [ccf_pkg::DATA_W-1:0]  piv_q;
	logic                               neg_q;

	logic                               out_valid_q, last_q;
	logic signed [ccf_pkg::DATA_W-1:0]  fe_q;
	logic [ccf_pkg::IDX_W-1:0]          row_q, col_q;

	// memories
	logic signed [ccf_pkg::DATA_W-1:0] mstore [2**ccf_pkg::ADDR_W];
	logic signed [ccf_pkg::DATA_W-1:0] fstore [2**ccf_pkg::ADDR_W];
	logic signed [ccf_pkg::DATA_W-1:0] m_rd, fa_rd, fb_rd;
	logic [ccf_pkg::ADDR_W-1:0]        m_addr, fa_addr, fb_addr;

	// derived values
	logic [ccf_pkg::DIM_W-1:0]  n_act;
	logic [ccf_pkg::IDX_W-1:0]  n_last;
	logic [ccf_pkg::CNT_W-1:0]  total;
	logic                       in_xfer, out_xfer;
	logic signed [ccf_pkg::RAD_W-1:0] prod_tr;
	logic signed [ccf_pkg::ACC_W-1:0] acc_sat_in;
	logic signed [ccf_pkg::DATA_W-1:0] s_sat;
	logic [ccf_pkg::ROOT_W+2:0] srem_sh, strial;
	logic [ccf_pkg::DATA_W:0]   drem_sh;
	logic [ccf_pkg::DATA_W-1:0] s_mag;
	logic                       entry_last;

	assign n_act   = ccf_pkg::active_dim(size_q);
	assign n_last  = ccf_pkg::IDX_W'(n_act - 1'b1);
	assign total   = ccf_pkg::CNT_W'(n_act * n_act);
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign entry_last = (i_q == n_last) && (j_q == n_last);

	assign in_stall       = (state_q != S_LOAD);
	assign out_valid      = out_valid_q;
	assign factor_element = fe_q;
	assign row_index      = row_q;
	assign column_index   = col_q;
	assign last_of_run    = last_q;

	// store addresses: matrix is row-major at size n, factor is {row, col}
	assign m_addr  = ccf_pkg::ADDR_W'(i_q * n_act + ccf_pkg::DIM_W'(j_q));
	assign fa_addr = (state_q == S_ERD) ? {i_q, j_q} : {i_q, k_q};
	assign fb_addr = (state_q == S_FIN) ? {j_q, j_q} : {j_q, k_q};

	always_ff @(posedge clk) begin
		if (in_xfer)
			mstore[load_q[ccf_pkg::ADDR_W-1:0]] <= matrix_element;
		m_rd <= mstore[m_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_WR)
			fstore[{i_q, j_q}] <= entry_q;
		fa_rd <= fstore[fa_addr];
		fb_rd <= fstore[fb_addr];
	end

	// product / 2^16, truncated toward zero
	always_comb begin
		prod_tr = ccf_pkg::RAD_W'(prod_q >>> ccf_pkg::FRAC_W);
		if (prod_q[ccf_pkg::PROD_W-1] && (prod_q[ccf_pkg::FRAC_W-1:0] != '0))
			prod_tr = prod_tr + 1'b1;
	end

	// saturate running sum to 32 bits
	assign acc_sat_in = acc_q;
	always_comb begin
		if (acc_sat_in > ccf_pkg::ACC_W'(ccf_pkg::S32_MAX))
			s_sat = ccf_pkg::S32_MAX;
		else if (acc_sat_in < ccf_pkg::ACC_W'(ccf_pkg::S32_MIN))
			s_sat = ccf_pkg::S32_MIN;
		else
			s_sat = acc_sat_in[ccf_pkg::DATA_W-1:0];
	end

	// one step of the digit-by-digit root and of the restoring divider
	assign srem_sh = {srem_q[ccf_pkg::ROOT_W:0], rad_q[ccf_pkg::RAD_W-1 -: 2]};
	assign strial  = {1'b0, root_q, 2'b01};
	assign drem_sh = {drem_q[ccf_pkg::DATA_W-1:0], rad_q[ccf_pkg::RAD_W-1]};
	assign s_mag   = s_q[ccf_pkg::DATA_W-1] ? ccf_pkg::DATA_W'(-s_q) : ccf_pkg::DATA_W'(s_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			size_q      <= ccf_pkg::RESET_DIM;
			load_q      <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			iter_q      <= '0;
			acc_q       <= '0;
			s_q         <= '0;
			prod_q      <= '0;
			entry_q     <= '0;
			rad_q       <= '0;
			srem_q      <= '0;
			root_q      <= '0;
			drem_q      <= '0;
			quot_q      <= '0;
			piv_q       <= '0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
			fe_q        <= '0;
			row_q       <= '0;
			col_q       <= '0;
		end else begin
			if (matrix_size_we) begin
				size_q <= matrix_size;
				load_q <= '0;
			end
			case (state_q)
				S_LOAD: begin
					if (in_xfer && !matrix_size_we) begin
						if (load_q + 1'b1 == total) begin
							load_q  <= '0;
							i_q     <= '0;
							j_q     <= '0;
							state_q <= S_MREAD;
						end else begin
							load_q <= load_q + 1'b1;
						end
					end
				end
				S_MREAD: begin
					k_q     <= '0;
					state_q <= S_MWAIT;
				end
				S_MWAIT: begin
					acc_q   <= ccf_pkg::ACC_W'(m_rd);
					state_q <= (j_q == '0) ? S_FIN : S_FRD;
				end
				S_FRD: state_q <= S_MUL;
				S_MUL: begin
					prod_q  <= ccf_pkg::PROD_W'(fa_rd) * ccf_pkg::PROD_W'(fb_rd);
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q   <= acc_q - ccf_pkg::ACC_W'(prod_tr);
					k_q     <= k_q + 1'b1;
					state_q <= (k_q + 1'b1 == j_q) ? S_FIN : S_FRD;
				end
				S_FIN: begin
					s_q <= s_sat;
					if (i_q == j_q) begin
						rad_q  <= {s_sat[ccf_pkg::DATA_W-1:0], {ccf_pkg::FRAC_W{1'b0}}};
						srem_q <= '0;
						root_q <= '0;
						iter_q <= ccf_pkg::ITER_W'(ccf_pkg::ROOT_W - 1);
						if (s_sat > 0) begin
							state_q <= S_SQRT;
						end else begin
							entry_q <= '0;
							state_q <= S_WR;
						end
					end else begin
						state_q <= S_PIV;
					end
				end
				S_PIV: begin
					piv_q  <= fb_rd;
					neg_q  <= s_q[ccf_pkg::DATA_W-1];
					rad_q  <= {s_mag, {ccf_pkg::FRAC_W{1'b0}}};
					drem_q <= '0;
					quot_q <= '0;
					iter_q <= ccf_pkg::ITER_W'(ccf_pkg::RAD_W - 1);
					if (fb_rd == '0) begin
						entry_q <= '0;
						state_q <= S_WR;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_SQRT: begin
					rad_q <= rad_q << 2;
					if (srem_sh >= strial) begin
						srem_q <= srem_sh - strial;
						root_q <= {root_q[ccf_pkg::ROOT_W-2:0], 1'b1};
					end else begin
						srem_q <= srem_sh;
						root_q <= {root_q[ccf_pkg::ROOT_W-2:0], 1'b0};
					end
					if (iter_q == '0) begin
						state_q <= S_WR;
					end
					iter_q <= iter_q - 1'b1;
				end
				S_DIV: begin
					rad_q <= rad_q << 1;
					if (drem_sh >= {1'b0, piv_q}) begin
						drem_q <= drem_sh - {1'b0, piv_q};
						quot_q <= {quot_q[ccf_pkg::RAD_W-2:0], 1'b1};
					end else begin
						drem_q <= drem_sh;
						quot_q <= {quot_q[ccf_pkg::RAD_W-2:0], 1'b0};
					end
					if (iter_q == '0) begin
						state_q <= S_WR;
					end
					iter_q <= iter_q - 1'b1;
				end
				S_WR: begin
					if (j_q < i_q) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_MREAD;
					end else if (i_q != n_last) begin
						i_q     <= i_q + 1'b1;
						j_q     <= '0;
						state_q <= S_MREAD;
					end else begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= S_ERD;
					end
				end
				S_ERD: state_q <= S_EOUT;
				S_EOUT: begin
					fe_q        <= (j_q > i_q) ? '0 : fa_rd;
					row_q       <= i_q;
					col_q       <= j_q;
					last_q      <= entry_last;
					out_valid_q <= 1'b1;
					state_q     <= S_EHOLD;
				end
				S_EHOLD: begin
					if (out_xfer) begin
						out_valid_q <= 1'b0;
						if (entry_last) begin
							state_q <= S_LOAD;
						end else begin
							if (j_q == n_last) begin
								j_q <= '0;
								i_q <= i_q + 1'b1;
							end else begin
								j_q <= j_q + 1'b1;
							end
							state_q <= S_ERD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase

			// finished root or quotient lands in the entry register
			if (state_q == S_SQRT && iter_q == '0) begin
				entry_q <= ccf_pkg::DATA_W'({root_q[ccf_pkg::ROOT_W-2:0],
					(srem_sh >= strial)});
			end
			if (state_q == S_DIV && iter_q == '0) begin
				if (neg_q) begin
					if ({quot_q[ccf_pkg::RAD_W-2:0], (drem_sh >= {1'b0, piv_q})} >=
						ccf_pkg::RAD_W'({1'b1, {(ccf_pkg::DATA_W-1){1'b0}}}))
						entry_q <= ccf_pkg::S32_MIN;
					else
						entry_q <= -ccf_pkg::DATA_W'({quot_q[ccf_pkg::RAD_W-2:0],
							(drem_sh >= {1'b0, piv_q})});
				end else begin
					if ({quot_q[ccf_pkg::RAD_W-2:0], (drem_sh >= {1'b0, piv_q})} >
						ccf_pkg::RAD_W'(ccf_pkg::S32_MAX))
						entry_q <= ccf_pkg::S32_MAX;
					else
						entry_q <= ccf_pkg::DATA_W'({quot_q[ccf_pkg::RAD_W-2:0],
							(drem_sh >= {1'b0, piv_q})});
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	// no input transfer while a result is on offer
	a_stall_on_output: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken during output");

	// the last result sits on the diagonal
	a_last_diag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_of_run) |-> (row_index == column_index))
		else $error("last result off the diagonal");

	// after the last result the block is ready for a new matrix
	a_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_of_run) |=> !in_stall)
		else $error("not ready after run");

	// upper-triangle results are zero
	a_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (column_index > row_index)) |-> (factor_element == '0))
		else $error("nonzero above diagonal");
`endif

endmodule
